FILE: src/marching_squares_contour_points_assert.svh
// assertion macros shared by the contour point modules
// plain text macros, no dependencies
`ifndef MARCHING_SQUARES_CONTOUR_POINTS_ASSERT_SVH
`define MARCHING_SQUARES_CONTOUR_POINTS_ASSERT_SVH

// condition holds at every edge out of reset
`define MSQ_ASSERT_ALWAYS(lbl, clock, resetn, cond, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MSQ_ASSERT_IMPLIES(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MSQ_ASSERT_NEXT(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/msq_pkg.sv
// shared types and constants of the marching squares contour point block
// no dependencies
`default_nettype none

package msq_pkg;

    localparam int ISO_W       = 16;
    localparam int CX_W        = 11;
    localparam int CY_W        = 16;
    localparam int COORD_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int EDGE_W      = 2;
    localparam int EDGES       = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ISOVALUE = 3'd0,
        REG_CELLS_X  = 3'd1,
        REG_CELLS_Y  = 3'd2,
        REG_X_ORIGIN = 3'd3,
        REG_Y_ORIGIN = 3'd4,
        REG_X_STEP   = 3'd5,
        REG_Y_STEP   = 3'd6
    } cfg_reg_t;

    typedef enum logic [EDGE_W-1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_LEFT   = 2'd3
    } edge_t;

    typedef struct packed {
        logic signed [ISO_W-1:0]   isovalue;
        logic [CX_W-1:0]           cells_x;
        logic [CY_W-1:0]           cells_y;
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] y_origin;
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] y_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        isovalue: 16'sd0,
        cells_x:  11'd1,
        cells_y:  16'd1,
        x_origin: 32'sd0,
        y_origin: 32'sd0,
        x_step:   32'sd65536,
        y_step:   32'sd65536
    };

endpackage

`default_nettype wire

FILE: src/marching_squares_contour_points.sv
// Marching squares contour points. Samples enter in raster order, one word per
// clock whenever full is low; a frame is cells_y+1 rows of cells_x+1 samples and the
// previous row sits in a line store ram read once per clock one column ahead. Each
// cell with a crossing becomes a job in a four-entry queue, and the point unit
// drains a job at one point per clock while the output queue has room: two points for
// most mixed cells, four for the saddle cases, none for cells fully above or below. The
// input sustains one sample per clock as long as points average at most one per clock;
// with both queues empty, the first point of a cell passes from the sample closing it
// through the job queue and then the point queue to the outputs. Points wait
// in a four-entry output queue, so a stalled reader never stops intake until both
// queues are full. Configuration is written through cfg_write/cfg_index/cfg_data
// while the block is idle; the line store needs no clearing after reset.
// depends on msq_pkg, msq_fifo, msq_front, msq_back
`default_nettype none

module marching_squares_contour_points #(
    parameter int MAX_CELLS_X = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [msq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [msq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                push,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                     full,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic signed [msq_pkg::COORD_W-1:0]       point_x,
    output logic signed [msq_pkg::COORD_W-1:0]       point_y,
    output logic [msq_pkg::EDGE_W-1:0]               edge_id,
    output logic                                     last_in_cell
);

    import msq_pkg::*;

    localparam int CNT_W   = $clog2(MAX_CELLS_X + 1);
    localparam int XC_W    = COORD_W + CNT_W + 1;
    localparam int YC_W    = COORD_W + CY_W + 1;
    localparam int JOB_W   = EDGES + 2 * XC_W + 2 * YC_W;
    localparam int POINT_W = 2 * COORD_W + EDGE_W + 1;
    localparam int QDEPTH  = 4;

    cfg_t               cfg_reg, cfg_next;
    logic               job_push;
    logic [JOB_W-1:0]   job_wdata;
    logic               job_full;
    logic               job_pop;
    logic [JOB_W-1:0]   job_rdata;
    logic               job_empty;
    logic               pt_push;
    logic [POINT_W-1:0] pt_wdata;
    logic               pt_full;
    logic [POINT_W-1:0] pt_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ISOVALUE: cfg_next.isovalue = cfg_data[ISO_W-1:0];
                REG_CELLS_X:  cfg_next.cells_x  = cfg_data[CX_W-1:0];
                REG_CELLS_Y:  cfg_next.cells_y  = cfg_data[CY_W-1:0];
                REG_X_ORIGIN: cfg_next.x_origin = cfg_data[COORD_W-1:0];
                REG_Y_ORIGIN: cfg_next.y_origin = cfg_data[COORD_W-1:0];
                REG_X_STEP:   cfg_next.x_step   = cfg_data[COORD_W-1:0];
                REG_Y_STEP:   cfg_next.y_step   = cfg_data[COORD_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    msq_front #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .job_push (job_push),
        .job_data (job_wdata),
        .job_full (job_full)
    );

    msq_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QDEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wdata),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    msq_back #(
        .MAX_CELLS_X (MAX_CELLS_X)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_rdata),
        .job_pop   (job_pop),
        .out_push  (pt_push),
        .out_data  (pt_wdata),
        .out_full  (pt_full)
    );

    msq_fifo #(
        .WIDTH (POINT_W),
        .DEPTH (QDEPTH)
    ) u_point_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pt_push),
        .wdata (pt_wdata),
        .full  (pt_full),
        .pop   (pop),
        .rdata (pt_rdata),
        .empty (empty)
    );

    assign {point_x, point_y, edge_id, last_in_cell} = pt_rdata;

endmodule

`default_nettype wire

FILE: src/msq_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module msq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/msq_fifo.sv
// small register queue used for cell jobs and for finished points
// uses the assertion macro header
`default_nettype none

module msq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_go;
    logic             rd_go;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_go = push && !full;
    assign rd_go = pop && !empty;
    assign rdata = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_go)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_go)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_go && !rd_go)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_go && !wr_go)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    `include "marching_squares_contour_points_assert.svh"

    `MSQ_ASSERT_ALWAYS(a_fifo_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "fifo count above depth")
    `MSQ_ASSERT_NEXT(a_fifo_count_up, clk, rst_n, wr_go && !rd_go, count_reg == $past(count_reg) + 1'b1, "fifo count did not grow on lone write")

endmodule

`default_nettype wire

FILE: src/msq_front.sv
// front end: raster counters, line store, corner classification, cell jobs
// uses msq_pkg, msq_ram and the assertion macro header
`default_nettype none

module msq_front #(
    parameter int MAX_CELLS_X = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire msq_pkg::cfg_t                 cfg,
    input  wire logic                          push,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               full,
    output logic                               job_push,
    output logic [msq_pkg::EDGES + 2 * (msq_pkg::COORD_W + $clog2(MAX_CELLS_X + 1) + 1)
                  + 2 * (msq_pkg::COORD_W + msq_pkg::CY_W + 1) - 1:0] job_data,
    input  wire logic                          job_full
);

    import msq_pkg::*;

    localparam int CNT_W    = $clog2(MAX_CELLS_X + 1);
    localparam int CX_CMP_W = (CNT_W > CX_W) ? CNT_W : CX_W;
    localparam int XC_W     = COORD_W + CNT_W + 1;
    localparam int YC_W     = COORD_W + CY_W + 1;
    localparam int CMP_W    = (SAMPLE_BITS > ISO_W) ? SAMPLE_BITS : ISO_W;
    localparam logic [CX_CMP_W-1:0] MAX_CX = CX_CMP_W'(MAX_CELLS_X);

    logic [CNT_W-1:0]              col_reg, col_next;
    logic [CY_W-1:0]               row_reg, row_next;
    logic signed [XC_W-1:0]        xc_reg, xc_next;
    logic signed [YC_W-1:0]        yc_reg, yc_next;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;

    logic                          accept;
    logic [CX_CMP_W-1:0]           cx_ext;
    logic [CX_CMP_W-1:0]           ecx;
    logic [CY_W-1:0]               ecy;
    logic                          col_end;
    logic                          row_end;
    logic [SAMPLE_BITS-1:0]        above_row;
    logic [CNT_W-1:0]              rd_addr;
    logic signed [CMP_W-1:0]       iso_ext;
    logic signed [CMP_W-1:0]       corner [EDGES];
    logic [EDGES-1:0]              above;
    logic [EDGES-1:0]              crossed;
    logic signed [XC_W-1:0]        xl;
    logic signed [YC_W-1:0]        yb;

    assign full   = job_full;
    assign accept = push && !job_full;

    // effective geometry: zero means one cell, width capped by the line store
    assign cx_ext  = CX_CMP_W'(cfg.cells_x);
    assign ecx     = (cx_ext == '0) ? CX_CMP_W'(1) : ((cx_ext > MAX_CX) ? MAX_CX : cx_ext);
    assign ecy     = (cfg.cells_y == '0) ? CY_W'(1) : cfg.cells_y;
    assign col_end = (CX_CMP_W'(col_reg) >= ecx);
    assign row_end = (row_reg >= ecy);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        xc_next  = xc_reg;
        yc_next  = yc_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                xc_next  = XC_W'(cfg.x_origin);
                if (row_end)
                begin
                    row_next = '0;
                    yc_next  = YC_W'(cfg.y_origin);
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    yc_next  = yc_reg + YC_W'(cfg.y_step);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                xc_next  = xc_reg + XC_W'(cfg.x_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            xc_reg  <= XC_W'(CFG_RESET.x_origin);
            yc_reg  <= YC_W'(CFG_RESET.y_origin);
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            xc_reg  <= xc_next;
            yc_reg  <= yc_next;
        end
    end

    // bottom-left comes from the line store one column back, top-left is the last sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg <= $signed(above_row);
            prev_reg <= sample;
        end
    end

    // prefetch the previous-row sample for the column the next word will land in
    assign rd_addr = accept ? col_next : col_reg;

    msq_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_CELLS_X + 1)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (above_row)
    );

    assign iso_ext   = CMP_W'(cfg.isovalue);
    assign corner[0] = CMP_W'(left_reg);
    assign corner[1] = CMP_W'($signed(above_row));
    assign corner[2] = CMP_W'(sample);
    assign corner[3] = CMP_W'(prev_reg);

    always_comb
    begin
        for (int k = 0; k < EDGES; k++)
        begin
            above[k] = (corner[k] > iso_ext);
        end
        for (int k = 0; k < EDGES; k++)
        begin
            crossed[k] = above[k] ^ above[(k + 1) % EDGES];
        end
    end

    assign xl       = xc_reg - XC_W'(cfg.x_step);
    assign yb       = yc_reg - YC_W'(cfg.y_step);
    assign job_push = accept && (col_reg != '0) && (row_reg != '0) && (crossed != '0);
    assign job_data = {crossed, xl, xc_reg, yb, yc_reg};

    `include "marching_squares_contour_points_assert.svh"

    `MSQ_ASSERT_NEXT(a_front_row_wrap, clk, rst_n, accept && col_end, col_reg == '0, "no column wrap")
    `MSQ_ASSERT_NEXT(a_front_row_hold, clk, rst_n, accept && !col_end, row_reg == $past(row_reg), "row moved")

endmodule

`default_nettype wire

FILE: src/msq_back.sv
// back end: walks the crossed edges of one cell job, one midpoint per cycle while the point queue has room
// uses msq_pkg and the assertion macro header
`default_nettype none

module msq_back #(
    parameter int MAX_CELLS_X = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_empty,
    input  wire logic [msq_pkg::EDGES + 2 * (msq_pkg::COORD_W + $clog2(MAX_CELLS_X + 1) + 1)
                       + 2 * (msq_pkg::COORD_W + msq_pkg::CY_W + 1) - 1:0] job_data,
    output logic      job_pop,
    output logic      out_push,
    output logic [2 * msq_pkg::COORD_W + msq_pkg::EDGE_W:0] out_data,
    input  wire logic out_full
);

    import msq_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS_X + 1);
    localparam int XC_W  = COORD_W + CNT_W + 1;
    localparam int YC_W  = COORD_W + CY_W + 1;
    localparam int SW    = ((XC_W > YC_W) ? XC_W : YC_W) + 1;

    logic [EDGES-1:0]          done_reg, done_next;
    logic [EDGES-1:0]          crossed;
    logic signed [XC_W-1:0]    xl;
    logic signed [XC_W-1:0]    xr;
    logic signed [YC_W-1:0]    yb;
    logic signed [YC_W-1:0]    yt;
    logic [EDGES-1:0]          pending;
    logic [EDGES-1:0]          sel_bit;
    logic [EDGES-1:0]          remaining;
    edge_t                     sel_edge;
    logic                      go;
    logic signed [XC_W:0]      x_sum;
    logic signed [YC_W:0]      y_sum;
    logic signed [XC_W:0]      x_mid;
    logic signed [YC_W:0]      y_mid;
    logic signed [SW-1:0]      px;
    logic signed [SW-1:0]      py;
    logic [COORD_W-1:0]        px_sat;
    logic [COORD_W-1:0]        py_sat;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic [SW-COORD_W:0] top;
        top = v[SW-1:COORD_W-1];
        if ((&top) || !(|top))
        begin
            return v[COORD_W-1:0];
        end
        return v[SW-1] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
    endfunction

    assign {crossed, xl, xr, yb, yt} = job_data;

    assign pending = crossed & ~done_reg;

    // edges go out in order bottom, right, top, left
    always_comb
    begin
        priority if (pending[EDGE_BOTTOM])
        begin
            sel_edge = EDGE_BOTTOM;
        end
        else if (pending[EDGE_RIGHT])
        begin
            sel_edge = EDGE_RIGHT;
        end
        else if (pending[EDGE_TOP])
        begin
            sel_edge = EDGE_TOP;
        end
        else
        begin
            sel_edge = EDGE_LEFT;
        end
    end

    assign sel_bit   = EDGES'(1) << sel_edge;
    assign remaining = pending & ~sel_bit;
    assign go        = !job_empty && !out_full;
    assign out_push  = go;
    assign job_pop   = go && (remaining == '0);

    always_comb
    begin
        done_next = done_reg;
        if (go)
        begin
            done_next = (remaining == '0) ? '0 : (done_reg | sel_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // midpoints: exact sum, halved toward minus infinity
    assign x_sum = (XC_W + 1)'(xl) + (XC_W + 1)'(xr);
    assign y_sum = (YC_W + 1)'(yb) + (YC_W + 1)'(yt);
    assign x_mid = x_sum >>> 1;
    assign y_mid = y_sum >>> 1;

    always_comb
    begin
        unique case (sel_edge)
            EDGE_BOTTOM:
            begin
                px = SW'(x_mid);
                py = SW'(yb);
            end
            EDGE_RIGHT:
            begin
                px = SW'(xr);
                py = SW'(y_mid);
            end
            EDGE_TOP:
            begin
                px = SW'(x_mid);
                py = SW'(yt);
            end
            default:
            begin
                px = SW'(xl);
                py = SW'(y_mid);
            end
        endcase
    end

    assign px_sat   = sat_coord(px);
    assign py_sat   = sat_coord(py);
    assign out_data = {px_sat, py_sat, sel_edge, remaining == '0};

    `include "marching_squares_contour_points_assert.svh"

    `MSQ_ASSERT_IMPLIES(a_back_idle_clear, clk, rst_n, job_empty, done_reg == '0, "stale progress")
    `MSQ_ASSERT_IMPLIES(a_back_done_subset, clk, rst_n, !job_empty, (done_reg & ~crossed) == '0, "bad edge")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for marching_squares_contour_points: raster samples in, contour midpoints out
// a scoreboard class keeps its own model of the line store and the grid walk
// depends on msq_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;

    import msq_pkg::*;

    localparam int SAMPLE_W        = 16;
    localparam int MAX_COLS        = 1024;
    localparam int RANDOM_ITEMS    = 310;
    localparam int IDLE_FREE_AFTER = 260;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam int STYLE_PLAIN = 0;
    localparam int STYLE_LOW   = 1;
    localparam int STYLE_HIGH  = 2;
    localparam int STYLE_WIDE  = 3;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        edge_t                     side;
        logic                      last;
    } point_t;

    class contour_board;
        cfg_t                       settings;
        logic signed [SAMPLE_W-1:0] line_mem [0:MAX_COLS];
        logic signed [SAMPLE_W-1:0] left_val;
        int unsigned                col;
        int unsigned                row;
        longint                     col_x;
        longint                     row_y;
        int                         max_col;
        point_t                     points_due [$];
        int                         failures;

        function new();
            settings = CFG_RESET;
            foreach (line_mem[i]) line_mem[i] = '0;
            left_val = '0;
            col = 0;
            row = 0;
            col_x = longint'($signed(CFG_RESET.x_origin));
            row_y = longint'($signed(CFG_RESET.y_origin));
            max_col = -1;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ISOVALUE: settings.isovalue = data[ISO_W-1:0];
                REG_CELLS_X:  settings.cells_x  = data[CX_W-1:0];
                REG_CELLS_Y:  settings.cells_y  = data[CY_W-1:0];
                REG_X_ORIGIN: settings.x_origin = data;
                REG_Y_ORIGIN: settings.y_origin = data;
                REG_X_STEP:   settings.x_step   = data;
                REG_Y_STEP:   settings.y_step   = data;
                default: ;
            endcase
        endfunction

        // a wider row mid-frame must not reach line store columns never written
        function logic [CX_W-1:0] fit_cells_x(logic [CX_W-1:0] want);
            int eff;
            eff = (want == 0) ? 1 : ((want > MAX_COLS) ? MAX_COLS : int'(want));
            if (row >= 1 && eff > max_col)
                return CX_W'(max_col);
            return want;
        endfunction

        function logic signed [COORD_W-1:0] clip(longint v);
            if (v > COORD_MAX)
                return COORD_MAX[COORD_W-1:0];
            if (v < COORD_MIN)
                return COORD_MIN[COORD_W-1:0];
            return v[COORD_W-1:0];
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned                ecx;
            int unsigned                ecy;
            int unsigned                c;
            logic signed [SAMPLE_W-1:0] corner [4];
            logic [3:0]                 above;
            longint                     xl, xr, yb, yt, px, py;
            point_t                     p;
            point_t                     cell_pts [$];
            int                         k;
            ecx = (settings.cells_x == 0) ? 1 :
                  ((settings.cells_x > MAX_COLS) ? MAX_COLS : settings.cells_x);
            ecy = (settings.cells_y == 0) ? 1 : settings.cells_y;
            c = (col > MAX_COLS) ? MAX_COLS : col;
            if (c >= 1 && row >= 1) begin
                // corners: bottom-left, bottom-right, top-right, top-left
                corner[0] = left_val;
                corner[1] = line_mem[c];
                corner[2] = s;
                corner[3] = line_mem[c-1];
                for (k = 0; k < 4; k++)
                    above[k] = corner[k] > settings.isovalue;
                xr = col_x;
                xl = col_x - longint'($signed(settings.x_step));
                yt = row_y;
                yb = row_y - longint'($signed(settings.y_step));
                for (k = 0; k < 4; k++) begin
                    if (above[k] != above[(k + 1) % 4]) begin
                        case (edge_t'(k))
                            EDGE_BOTTOM: begin px = (xl + xr) >>> 1; py = yb; end
                            EDGE_RIGHT:  begin px = xr; py = (yb + yt) >>> 1; end
                            EDGE_TOP:    begin px = (xl + xr) >>> 1; py = yt; end
                            default:     begin px = xl; py = (yb + yt) >>> 1; end
                        endcase
                        p.x = clip(px);
                        p.y = clip(py);
                        p.side = edge_t'(k);
                        p.last = 1'b0;
                        cell_pts = {cell_pts, p};
                    end
                end
                if (cell_pts.size() > 0)
                    cell_pts[cell_pts.size() - 1].last = 1'b1;
                foreach (cell_pts[i]) points_due = {points_due, cell_pts[i]};
            end
            left_val = line_mem[c];
            line_mem[c] = s;
            if (int'(c) > max_col)
                max_col = c;
            if (col >= ecx) begin
                col = 0;
                col_x = longint'($signed(settings.x_origin));
                if (row >= ecy) begin
                    row = 0;
                    row_y = longint'($signed(settings.y_origin));
                end else begin
                    row++;
                    row_y += longint'($signed(settings.y_step));
                end
            end else begin
                col++;
                col_x += longint'($signed(settings.x_step));
            end
        endfunction

        function void match_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic [EDGE_W-1:0] side, logic last);
            point_t want;
            if (points_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected point: x=%0d y=%0d edge=%0d last=%0b",
                             x, y, side, last);
                return;
            end
            want = points_due.pop_front();
            if (want.x !== x || want.y !== y || want.side !== side || want.last !== last) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"point mismatch: expected x=%0d y=%0d edge=%0d last=%0b, ",
                              "got x=%0d y=%0d edge=%0d last=%0b"},
                             want.x, want.y, want.side, want.last, x, y, side, last);
            end
        endfunction

        function int pending();
            return points_due.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         push;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         full;
    logic                         pop;
    logic                         empty;
    logic signed [COORD_W-1:0]    point_x;
    logic signed [COORD_W-1:0]    point_y;
    logic [EDGE_W-1:0]            edge_id;
    logic                         last_in_cell;

    contour_board board;
    bit           no_idle = 1'b0;
    bit           pressing = 1'b0;
    bit           hold_now = 1'b0;
    int           sent = 0;
    int           cycle_count = 0;

    // one frame per four words at the reset grid: bottom-left, bottom-right, top-left, top-right
    logic signed [SAMPLE_W-1:0] corner_tests [0:23] = '{
        16'sh8000, 16'sd0, -16'sd1, 16'sd0,           // all below, sample equal to threshold
        16'sd32767, 16'sd1, 16'sd1, 16'sd32767,       // all above
        16'sd32767, 16'sh8000, 16'sh8000, 16'sd32767, // saddle, bottom-left and top-right above
        -16'sd5, 16'sd5, 16'sd5, -16'sd5,             // saddle, bottom-right and top-left above
        16'sd7, 16'sd0, 16'sd0, 16'sd0,               // one corner above
        16'sd0, 16'sd9, 16'sd0, 16'sd9                // right side above
    };

    marching_squares_contour_points #(
        .MAX_CELLS_X(MAX_COLS),
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .sample(sample),
        .full(full),
        .pop(pop),
        .empty(empty),
        .point_x(point_x),
        .point_y(point_y),
        .edge_id(edge_id),
        .last_in_cell(last_in_cell)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic put_sample(input logic signed [SAMPLE_W-1:0] s);
        push   <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.take_sample(s);
    endtask

    task automatic offer(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (!no_idle && !pressing && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        put_sample(s);
    endtask

    // drain every expected point, then give words that make no point time to pass
    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(bit far);
        int iso;
        int v;
        int r;
        iso = board.settings.isovalue;
        if (far)
        begin
            v = $urandom_range(1000, 32767);
            return ($urandom_range(0, 1) == 1) ? SAMPLE_W'(v) : SAMPLE_W'(-v);
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) == 1) ? 16'sd32767 : 16'sh8000;
        if (r <= 2)
            return SAMPLE_W'($urandom());
        // near the threshold so that cells cross often
        v = iso + int'($urandom_range(0, 40)) - 20;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_W'(v);
    endfunction

    task automatic run_phase(input int count, input bit far);
        for (int i = 0; i < count; i++)
        begin
            offer(pick_sample(far));
            sent++;
            if (sent >= IDLE_FREE_AFTER)
                no_idle = 1'b1;
        end
    endtask

    task automatic new_settings(input int style);
        logic [CFG_DATA_W-1:0] val [0:6];
        logic [CFG_DATA_W-1:0] junk;
        logic [CX_W-1:0]       cx;
        bit                    all;
        all  = (style != STYLE_PLAIN);
        junk = $urandom();
        case (style)
            STYLE_LOW:
            begin
                val[REG_ISOVALUE] = {junk[31:16], 16'h8000};
                cx                = '0;
                val[REG_CELLS_Y]  = {junk[31:16], 16'h0000};
                val[REG_X_ORIGIN] = 32'h8000_0000;
                val[REG_Y_ORIGIN] = 32'h8000_0000;
                val[REG_X_STEP]   = 32'h8000_0000;
                val[REG_Y_STEP]   = 32'h8000_0000;
            end
            STYLE_HIGH:
            begin
                val[REG_ISOVALUE] = {junk[31:16], 16'($urandom_range(0, 400) - 200)};
                cx                = CX_W'($urandom_range(1, 4));
                val[REG_CELLS_Y]  = $urandom_range(1, 3);
                val[REG_X_ORIGIN] = 32'h7FFF_FFFF;
                val[REG_Y_ORIGIN] = 32'h7FFF_FFFF;
                val[REG_X_STEP]   = 32'h7FFF_FFFF;
                val[REG_Y_STEP]   = 32'h7FFF_FFFF;
            end
            STYLE_WIDE:
            begin
                val[REG_ISOVALUE] = {junk[31:16], 16'h7FFF};
                cx                = ($urandom_range(0, 1) == 1) ? 11'd1024 : 11'd2047;
                val[REG_CELLS_Y]  = {junk[31:16], 16'hFFFF};
                val[REG_X_ORIGIN] = $urandom();
                val[REG_Y_ORIGIN] = $urandom();
                val[REG_X_STEP]   = $urandom();
                val[REG_Y_STEP]   = $urandom();
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    val[REG_ISOVALUE] = $urandom();
                else
                    val[REG_ISOVALUE] = {junk[31:16], 16'($urandom_range(0, 400) - 200)};
                if ($urandom_range(0, 9) == 0)
                    cx = CX_W'($urandom_range(6, 40));
                else
                    cx = CX_W'($urandom_range(1, 5));
                val[REG_CELLS_Y] = {junk[31:16], 16'($urandom_range(0, 5))};
                for (int i = REG_X_ORIGIN; i <= REG_Y_ORIGIN; i++)
                    val[i] = ($urandom_range(0, 4) == 0) ? $urandom() :
                             $urandom_range(0, 32'h20_0000) - 32'h10_0000;
                for (int i = REG_X_STEP; i <= REG_Y_STEP; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        val[i] = '0;
                    else if ($urandom_range(0, 5) == 0)
                        val[i] = $urandom();
                    else
                        val[i] = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
                end
            end
        endcase
        val[REG_CELLS_X] = {junk[31:CX_W], board.fit_cells_x(cx)};
        for (int i = REG_ISOVALUE; i <= REG_Y_STEP; i++)
            if (all || $urandom_range(0, 1) == 1)
                write_reg(cfg_reg_t'(i), val[i]);
        if (all || $urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom());
        cfg_write <= 1'b0;
    endtask

    // reader side: random stalls plus one long hold while the writer keeps pushing
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.match_point(point_x, point_y, edge_id, last_in_cell);
            if (hold_now)
            begin
                hold_now  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        board = new();
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        push      <= 1'b0;
        sample    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_tests[i])
            offer(corner_tests[i]);
        settle();

        new_settings(STYLE_WIDE);
        run_phase(30, 1'b0);
        settle();
        new_settings(STYLE_LOW);
        run_phase(30, 1'b0);
        settle();
        new_settings(STYLE_HIGH);
        run_phase(30, 1'b0);
        settle();

        // fill both internal queues behind a stalled reader
        new_settings(STYLE_PLAIN);
        @(posedge clk);
        write_reg(REG_ISOVALUE, '0);
        write_reg(REG_CELLS_X, {21'd0, board.fit_cells_x(11'd3)});
        cfg_write <= 1'b0;
        pressing = 1'b1;
        hold_now = 1'b1;
        run_phase(60, 1'b1);
        pressing = 1'b0;
        settle();

        while (sent < RANDOM_ITEMS)
        begin
            new_settings(STYLE_PLAIN);
            run_phase($urandom_range(15, 45), 1'b0);
            settle();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/msq_pkg.sv
src/msq_ram.sv
src/msq_fifo.sv
src/msq_front.sv
src/msq_back.sv
src/marching_squares_contour_points.sv
tb/sv/testbench.sv
